FILE: src/otr_pkg.sv
// otr_pkg: shared types and constants of the single-wire temperature reader
// register indexes, reset values, bus commands and the item structs
// no dependencies
`default_nettype none

package otr_pkg;

    parameter int TICK_COUNTER_WIDTH_DEF = 16;

    parameter int NUM_REGS    = 8;
    parameter int REG_INDEX_W = 3;
    parameter int CFG_W       = 16;
    parameter int TEMP_W      = 14;
    parameter int DIGIT_W     = 4;
    parameter int RAW_W       = 11;

    typedef enum logic [REG_INDEX_W-1:0] {
        REG_PRE_RESET_HIGH,
        REG_RESET_LOW,
        REG_RESET_HIGH,
        REG_SLOT_LOW,
        REG_READ_SAMPLE,
        REG_READ_TAIL,
        REG_WRITE_HOLD,
        REG_RECOVERY
    } reg_index_t;

    parameter logic [CFG_W-1:0] REG_RESET [NUM_REGS] = '{
        16'd10, 16'd500, 16'd500, 16'd6, 16'd8, 16'd45, 16'd50, 16'd10
    };

    parameter logic [7:0]  CMD_SKIP_ROM = 8'hCC;
    parameter logic [7:0]  CMD_CONVERT  = 8'h44;
    parameter logic [7:0]  CMD_READ_PAD = 8'hBE;
    parameter logic [15:0] RAW_MASK     = 16'h07FF;

    typedef struct packed {
        logic drive_low;
        logic reading_done;
    } seq_result_t;

    typedef struct packed {
        logic [TEMP_W-1:0]  temperature_centi;
        logic [DIGIT_W-1:0] digit_ten_thousands;
        logic [DIGIT_W-1:0] digit_thousands;
        logic [DIGIT_W-1:0] digit_hundreds;
        logic [DIGIT_W-1:0] digit_tens;
        logic [DIGIT_W-1:0] digit_ones;
    } reading_t;

endpackage

`default_nettype wire

FILE: src/otr_sequencer.sv
// otr_sequencer: bus timing sequencer, one item per timer tick
// holds the timing registers, the step/phase/tick state and the temperature
// depends on otr_pkg
`default_nettype none

module otr_sequencer #(
    parameter int TICK_COUNTER_WIDTH = otr_pkg::TICK_COUNTER_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [otr_pkg::REG_INDEX_W-1:0]     cfg_index,
    input  wire logic [otr_pkg::CFG_W-1:0]           cfg_data,
    input  wire logic                                step_en,
    input  wire logic                                bus_level,
    output otr_pkg::seq_result_t                     result,
    output logic [otr_pkg::TEMP_W-1:0]               temperature
);

    localparam int CMP_W = ((TICK_COUNTER_WIDTH > otr_pkg::CFG_W) ?
                            TICK_COUNTER_WIDTH : otr_pkg::CFG_W) + 1;

    localparam logic [3:0] STEP_RESET_CONVERT = 4'd0;
    localparam logic [3:0] STEP_SKIP_CONVERT  = 4'd1;
    localparam logic [3:0] STEP_CONVERT       = 4'd2;
    localparam logic [3:0] STEP_RESET_READ    = 4'd3;
    localparam logic [3:0] STEP_SKIP_READ     = 4'd4;
    localparam logic [3:0] STEP_READ_PAD      = 4'd5;
    localparam logic [3:0] STEP_READ_LOW      = 4'd6;
    localparam logic [3:0] STEP_READ_HIGH     = 4'd7;

    typedef enum logic [1:0] {
        KIND_RESET,
        KIND_WRITE,
        KIND_READ
    } kind_t;

    logic [otr_pkg::CFG_W-1:0]    cfg_reg [otr_pkg::NUM_REGS];
    logic [3:0]                   step_reg;
    logic [2:0]                   phase_reg;
    logic [TICK_COUNTER_WIDTH-1:0] tick_reg;
    logic [2:0]                   bit_reg;
    logic [7:0]                   shift_reg;
    logic [7:0]                   low_reg;
    logic [otr_pkg::TEMP_W-1:0]   temp_reg;
    otr_pkg::seq_result_t         result_reg;

    logic [3:0]                   step_next;
    logic [2:0]                   phase_next;
    logic [TICK_COUNTER_WIDTH-1:0] tick_next;
    logic [2:0]                   bit_next;
    logic [7:0]                   shift_next;
    logic [7:0]                   low_next;
    logic [otr_pkg::TEMP_W-1:0]   temp_next;
    logic                         done_next;
    logic                         drive_next;

    logic [3:0]                   seq;
    kind_t                        kind;
    logic [2:0]                   num_phases;
    logic [7:0]                   cmd;
    logic [otr_pkg::CFG_W-1:0]    dur_raw;
    logic [otr_pkg::CFG_W-1:0]    dur;
    logic                         phase_end;
    logic [2:0]                   phase_inc;
    logic [2:0]                   bit_inc;
    logic [15:0]                  word;
    logic [otr_pkg::RAW_W-1:0]    raw;
    logic [15:0]                  scaled;

    always_comb
    begin
        seq = (step_reg > STEP_READ_HIGH) ? STEP_RESET_CONVERT : step_reg;

        unique case (seq) inside
            STEP_RESET_CONVERT, STEP_RESET_READ:
            begin
                kind       = KIND_RESET;
                num_phases = 3'd3;
            end
            STEP_READ_LOW, STEP_READ_HIGH:
            begin
                kind       = KIND_READ;
                num_phases = 3'd4;
            end
            default:
            begin
                kind       = KIND_WRITE;
                num_phases = 3'd3;
            end
        endcase

        unique case (seq)
            STEP_CONVERT:  cmd = otr_pkg::CMD_CONVERT;
            STEP_READ_PAD: cmd = otr_pkg::CMD_READ_PAD;
            default:       cmd = otr_pkg::CMD_SKIP_ROM;
        endcase

        // phases past the last of a step are a single released tick
        drive_next = 1'b0;
        dur_raw    = otr_pkg::CFG_W'(1);
        case (kind)
            KIND_RESET:
            begin
                case (phase_reg)
                    3'd0: dur_raw = cfg_reg[otr_pkg::REG_PRE_RESET_HIGH];
                    3'd1:
                    begin
                        drive_next = 1'b1;
                        dur_raw    = cfg_reg[otr_pkg::REG_RESET_LOW];
                    end
                    3'd2: dur_raw = cfg_reg[otr_pkg::REG_RESET_HIGH];
                    default: dur_raw = otr_pkg::CFG_W'(1);
                endcase
            end
            KIND_WRITE:
            begin
                case (phase_reg)
                    3'd0:
                    begin
                        drive_next = 1'b1;
                        dur_raw    = cfg_reg[otr_pkg::REG_SLOT_LOW];
                    end
                    3'd1:
                    begin
                        drive_next = ~cmd[bit_reg];
                        dur_raw    = cfg_reg[otr_pkg::REG_WRITE_HOLD];
                    end
                    3'd2: dur_raw = cfg_reg[otr_pkg::REG_RECOVERY];
                    default: dur_raw = otr_pkg::CFG_W'(1);
                endcase
            end
            default:
            begin
                case (phase_reg)
                    3'd0:
                    begin
                        drive_next = 1'b1;
                        dur_raw    = cfg_reg[otr_pkg::REG_SLOT_LOW];
                    end
                    3'd1: dur_raw = cfg_reg[otr_pkg::REG_READ_SAMPLE];
                    3'd2: dur_raw = cfg_reg[otr_pkg::REG_READ_TAIL];
                    3'd3: dur_raw = cfg_reg[otr_pkg::REG_RECOVERY];
                    default: dur_raw = otr_pkg::CFG_W'(1);
                endcase
            end
        endcase
        dur = (dur_raw == '0) ? otr_pkg::CFG_W'(1) : dur_raw;

        // sample on the first tick of the read tail, lsb first
        shift_next = shift_reg;
        if (kind == KIND_READ && phase_reg == 3'd2 && tick_reg == '0)
        begin
            shift_next = {bus_level, shift_reg[7:1]};
        end

        // 25/4 scale as shift and add, truncated
        word   = {shift_next, low_reg} & otr_pkg::RAW_MASK;
        raw    = word[otr_pkg::RAW_W-1:0];
        scaled = (16'(raw) << 4) + (16'(raw) << 3) + 16'(raw);

        phase_end = (CMP_W'(tick_reg) + CMP_W'(1) >= CMP_W'(dur)) || (tick_reg == '1);
        phase_inc = phase_reg + 3'd1;
        bit_inc   = bit_reg + 3'd1;

        step_next  = seq;
        phase_next = phase_reg;
        tick_next  = tick_reg + TICK_COUNTER_WIDTH'(1);
        bit_next   = bit_reg;
        low_next   = low_reg;
        temp_next  = temp_reg;
        done_next  = 1'b0;

        if (phase_end)
        begin
            tick_next = '0;
            if (phase_inc >= num_phases || phase_inc == 3'd0)
            begin
                phase_next = 3'd0;
                if (kind == KIND_RESET)
                begin
                    step_next = seq + 4'd1;
                end
                else
                begin
                    bit_next = bit_inc;
                    if (bit_inc == 3'd0)
                    begin
                        if (seq == STEP_READ_LOW)
                        begin
                            low_next  = shift_next;
                            step_next = STEP_READ_HIGH;
                        end
                        else if (seq == STEP_READ_HIGH)
                        begin
                            temp_next = scaled[otr_pkg::TEMP_W+1:2];
                            done_next = 1'b1;
                            step_next = STEP_RESET_CONVERT;
                        end
                        else
                        begin
                            step_next = seq + 4'd1;
                        end
                    end
                end
            end
            else
            begin
                phase_next = phase_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < otr_pkg::NUM_REGS; i++)
            begin
                cfg_reg[i] <= otr_pkg::REG_RESET[i];
            end
            step_reg  <= STEP_RESET_CONVERT;
            phase_reg <= '0;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            low_reg   <= '0;
            temp_reg  <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                cfg_reg[cfg_index] <= cfg_data;
            end
            if (step_en)
            begin
                step_reg  <= step_next;
                phase_reg <= phase_next;
                tick_reg  <= tick_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
                low_reg   <= low_next;
                temp_reg  <= temp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            result_reg.drive_low    <= drive_next;
            result_reg.reading_done <= done_next;
        end
    end

    assign result      = result_reg;
    assign temperature = temp_reg;

`ifndef ASSERT_OFF
    a_done_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && done_next |=> step_reg == STEP_RESET_CONVERT && phase_reg == 3'd0
            && bit_reg == 3'd0 && tick_reg == '0)
        else $error("sequence did not restart after a completed reading");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg < 3'd4 && step_reg <= STEP_READ_HIGH)
        else $error("slot phase or sequence step out of range");

    a_write_bit_kept: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && kind == KIND_WRITE && !phase_end |=> $stable(bit_reg) && $stable(step_reg))
        else $error("bit index moved inside a slot");
`endif

endmodule

`default_nettype wire

FILE: src/otr_digits.sv
// otr_digits: result stage, splits the temperature into five decimal digits
// reciprocal multiplies into a registered reading
// depends on otr_pkg
`default_nettype none

module otr_digits (
    input  wire logic                       clk,
    input  wire logic                       load,
    input  wire logic [otr_pkg::TEMP_W-1:0] temperature,
    output otr_pkg::reading_t               reading
);

    // exact over the whole 14-bit range
    localparam logic [15:0] RECIP_10    = 16'd52429;
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam logic [14:0] RECIP_1000  = 15'd16778;
    localparam logic [13:0] RECIP_10000 = 14'd13422;

    otr_pkg::reading_t    reading_reg;
    otr_pkg::reading_t    reading_next;

    logic [29:0]          prod_10;
    logic [26:0]          prod_100;
    logic [28:0]          prod_1000;
    logic [27:0]          prod_10000;
    logic [10:0]          q_10;
    logic [7:0]           q_100;
    logic [4:0]           q_1000;
    logic                 q_10000;
    logic [otr_pkg::TEMP_W-1:0] rem_1;
    logic [otr_pkg::TEMP_W-1:0] rem_10;
    logic [otr_pkg::TEMP_W-1:0] rem_100;
    logic [otr_pkg::TEMP_W-1:0] rem_1000;

    function automatic logic [otr_pkg::TEMP_W-1:0] times_ten(
        input logic [otr_pkg::TEMP_W-1:0] v);
        return (v << 3) + (v << 1);
    endfunction

    always_comb
    begin
        prod_10    = 30'(temperature) * 30'(RECIP_10);
        prod_100   = 27'(temperature) * 27'(RECIP_100);
        prod_1000  = 29'(temperature) * 29'(RECIP_1000);
        prod_10000 = 28'(temperature) * 28'(RECIP_10000);

        q_10    = prod_10[29:19];
        q_100   = prod_100[26:19];
        q_1000  = prod_1000[28:24];
        q_10000 = prod_10000[27];

        rem_1    = temperature - times_ten(otr_pkg::TEMP_W'(q_10));
        rem_10   = otr_pkg::TEMP_W'(q_10) - times_ten(otr_pkg::TEMP_W'(q_100));
        rem_100  = otr_pkg::TEMP_W'(q_100) - times_ten(otr_pkg::TEMP_W'(q_1000));
        rem_1000 = otr_pkg::TEMP_W'(q_1000) - times_ten(otr_pkg::TEMP_W'(q_10000));

        reading_next.temperature_centi   = temperature;
        reading_next.digit_ten_thousands = otr_pkg::DIGIT_W'(q_10000);
        reading_next.digit_thousands     = rem_1000[otr_pkg::DIGIT_W-1:0];
        reading_next.digit_hundreds      = rem_100[otr_pkg::DIGIT_W-1:0];
        reading_next.digit_tens          = rem_10[otr_pkg::DIGIT_W-1:0];
        reading_next.digit_ones          = rem_1[otr_pkg::DIGIT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            reading_reg <= reading_next;
        end
    end

    assign reading = reading_reg;

endmodule

`default_nettype wire

FILE: src/one_wire_temperature_reader.sv
// one_wire_temperature_reader: top level of the single-wire temperature reader
// sequencer stage and digit stage with valid/stall handshake between them
// depends on otr_pkg, otr_sequencer, otr_digits
//
// channel   direction  handshake             item payload
// input     in         in_valid / in_stall   bus_level
// output    out        out_valid / out_stall drive_low, reading_done,
//                                            temperature_centi, digit_*
// config    in         cfg_write             cfg_index, cfg_data
//
// one item per clock unless the output stalls, one tick of bus timing per item
// result item registered in the sequencer stage when its input item is accepted,
// then digit split into the output register
// reset loads the timing registers with their defaults, no clearing pass
// a stalled output holds its item; the sequencer stage keeps accepting until full
`default_nettype none

module one_wire_temperature_reader #(
    parameter int TICK_COUNTER_WIDTH = otr_pkg::TICK_COUNTER_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [otr_pkg::REG_INDEX_W-1:0] cfg_index,
    input  wire logic [otr_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            bus_level,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 drive_low,
    output logic                                 reading_done,
    output logic [otr_pkg::TEMP_W-1:0]           temperature_centi,
    output logic [otr_pkg::DIGIT_W-1:0]          digit_ten_thousands,
    output logic [otr_pkg::DIGIT_W-1:0]          digit_thousands,
    output logic [otr_pkg::DIGIT_W-1:0]          digit_hundreds,
    output logic [otr_pkg::DIGIT_W-1:0]          digit_tens,
    output logic [otr_pkg::DIGIT_W-1:0]          digit_ones
);

    logic                       s1_valid_reg;
    logic                       out_valid_reg;
    otr_pkg::seq_result_t       out_flags_reg;
    otr_pkg::seq_result_t       s1_result;
    otr_pkg::reading_t          reading;
    logic [otr_pkg::TEMP_W-1:0] temperature;
    logic                       out_ready;
    logic                       s1_ready;
    logic                       s1_move;
    logic                       accept;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_move   = s1_valid_reg && out_ready;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign accept    = in_valid && s1_ready;
    assign in_stall  = !s1_ready;

    otr_sequencer #(
        .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
    ) u_sequencer (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .step_en     (accept),
        .bus_level   (bus_level),
        .result      (s1_result),
        .temperature (temperature)
    );

    otr_digits u_digits (
        .clk         (clk),
        .load        (s1_move),
        .temperature (temperature),
        .reading     (reading)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_flags_reg <= s1_result;
        end
    end

    assign out_valid           = out_valid_reg;
    assign drive_low           = out_flags_reg.drive_low;
    assign reading_done        = out_flags_reg.reading_done;
    assign temperature_centi   = reading.temperature_centi;
    assign digit_ten_thousands = reading.digit_ten_thousands;
    assign digit_thousands     = reading.digit_thousands;
    assign digit_hundreds      = reading.digit_hundreds;
    assign digit_tens          = reading.digit_tens;
    assign digit_ones          = reading.digit_ones;

`ifndef ASSERT_OFF
    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_ready |=> s1_valid_reg)
        else $error("sequencer item dropped while output stalled");

    a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> out_valid_reg)
        else $error("item left the sequencer stage but no output followed");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted item not held in the sequencer stage");
`endif

endmodule

`default_nettype wire
